FILE: sv/rhc_pkg.sv
// Shared types, constants and the long-division step for the RGB to HSV converter.
`default_nettype none

package rhc_pkg;

    // Field widths.
    localparam int unsigned ChanW = 8;
    localparam int unsigned HueW  = 15;
    localparam int unsigned SatW  = 16;

    // Long division: dividend bits, divisor bits and bits retired per stage.
    localparam int unsigned NumW         = 24;
    localparam int unsigned DenW         = ChanW + 1;
    localparam int unsigned BitsPerStage = 4;
    localparam int unsigned DivStages    = NumW / BitsPerStage;

    // Hue constants in 1/64 degree units.
    localparam logic [HueW-1:0] HueBaseRed   = 15'd0;
    localparam logic [HueW-1:0] HueBaseGreen = 15'd7680;
    localparam logic [HueW-1:0] HueBaseBlue  = 15'd15360;
    localparam logic [HueW:0]   HueFull      = 16'd23040;
    // Twice sixty degrees, the scale of the hue numerator.
    localparam logic [NumW-1:0] HueSixthX2   = 24'd7680;

    // One lane of the restoring divider.
    typedef struct packed {
        logic [NumW-1:0] num;
        logic [DenW-1:0] den;
        logic [DenW-1:0] rem;
        logic [NumW-1:0] quo;
    } t_lane;

    // Per-pixel side information that travels with the divider lanes.
    typedef struct packed {
        logic [ChanW-1:0] value;
        logic             undef;
        logic             neg;
        logic [HueW-1:0]  base;
    } t_side;

    // Retire BitsPerStage quotient bits, most significant dividend bit first.
    function automatic t_lane div_step(input t_lane l);
        t_lane       o;
        logic [DenW:0] trial;
        o = l;
        for (int i = 0; i < BitsPerStage; i++) begin
            trial = {o.rem, o.num[NumW-1]};
            o.num = {o.num[NumW-2:0], 1'b0};
            if (trial >= {1'b0, o.den}) begin
                o.rem = DenW'(trial - {1'b0, o.den});
                o.quo = {o.quo[NumW-2:0], 1'b1};
            end else begin
                o.rem = trial[DenW-1:0];
                o.quo = {o.quo[NumW-2:0], 1'b0};
            end
        end
        return o;
    endfunction

endpackage

`default_nettype wire

FILE: sv/rgb_to_hsv_converter_core.sv
// Pipelined RGB to hexcone HSV converter, one pixel per cycle while the receiver does not stall.
//
// Usage notes:
// - Input channel: i_valid, i_red, i_green, i_blue, with o_stall back to the
//   sender. A request is taken at a rising edge with i_valid high and o_stall low.
// - Output channel: o_valid, o_hue, o_saturation, o_value, o_hue_undefined,
//   with i_stall from the receiver. A result is taken when o_valid is high and
//   i_stall is low.
// - Throughput is one pixel per cycle while i_stall is low. From acceptance to
//   o_valid a pixel passes an input register, a front stage (max, min, sector,
//   numerators), six divider stages of four restoring steps each, and the output
//   stage. The divider depth (24 dividend bits at four bits per stage) sets latency.
// - Saturation and hue each use their own divider lane running side by side.
// - When the receiver stalls, the pipeline compacts: a stage holds only if it
//   is full and the stage after it holds. o_stall rises once every stage is full and i_stall is high.
// - Reset clears all valid bits; the data registers are not reset.
// - Grey and black pixels give hue 0, saturation 0 and o_hue_undefined high.
`default_nettype none

module rgb_to_hsv_converter_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic [rhc_pkg::ChanW-1:0]  i_red,
    input  wire logic [rhc_pkg::ChanW-1:0]  i_green,
    input  wire logic [rhc_pkg::ChanW-1:0]  i_blue,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic [rhc_pkg::HueW-1:0]        o_hue,
    output logic [rhc_pkg::SatW-1:0]        o_saturation,
    output logic [rhc_pkg::ChanW-1:0]       o_value,
    output logic                            o_hue_undefined
);

    localparam int unsigned NumSt = rhc_pkg::DivStages + 3;
    localparam int unsigned OutSt = NumSt - 1;

    // Valid bits per stage and per-stage advance enables.
    logic [NumSt-1:0] r_vld;
    logic [NumSt-1:0] w_adv;

    // Input register.
    logic [rhc_pkg::ChanW-1:0] r_red, r_green, r_blue;

    // Front stage result is index 0; divider stage j writes index j.
    rhc_pkg::t_lane r_sat_ln [0:rhc_pkg::DivStages];
    rhc_pkg::t_lane r_hue_ln [0:rhc_pkg::DivStages];
    rhc_pkg::t_side r_side   [0:rhc_pkg::DivStages];

    // Output registers.
    logic [rhc_pkg::HueW-1:0]  r_hue;
    logic [rhc_pkg::SatW-1:0]  r_sat;
    logic [rhc_pkg::ChanW-1:0] r_value;
    logic                      r_undef;

    // A stage moves when it is empty or the stage after it moves.
    always_comb begin
        w_adv[OutSt] = !r_vld[OutSt] || !i_stall;
        for (int k = OutSt - 1; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign o_stall = !w_adv[0];

    // Valid bits follow the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NumSt; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Capture the request.
    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_red   <= i_red;
            r_green <= i_green;
            r_blue  <= i_blue;
        end
    end

    // Front stage: extremes, sector choice and both dividends and divisors.
    logic [rhc_pkg::ChanW-1:0] w_max, w_min, w_delta;
    logic [rhc_pkg::ChanW:0]   w_diff;
    logic [rhc_pkg::ChanW-1:0] w_abs;
    logic                      w_neg;
    logic [rhc_pkg::HueW-1:0]  w_base;
    rhc_pkg::t_lane            n_sat_ln, n_hue_ln;
    rhc_pkg::t_side            n_side;

    always_comb begin
        w_max = r_red;
        if (r_green > w_max) w_max = r_green;
        if (r_blue > w_max)  w_max = r_blue;
        w_min = r_red;
        if (r_green < w_min) w_min = r_green;
        if (r_blue < w_min)  w_min = r_blue;
        w_delta = w_max - w_min;

        // Red wins ties over green, green over blue.
        priority if (r_red == w_max) begin
            w_diff = {1'b0, r_green} - {1'b0, r_blue};
            w_base = rhc_pkg::HueBaseRed;
        end else if (r_green == w_max) begin
            w_diff = {1'b0, r_blue} - {1'b0, r_red};
            w_base = rhc_pkg::HueBaseGreen;
        end else begin
            w_diff = {1'b0, r_red} - {1'b0, r_green};
            w_base = rhc_pkg::HueBaseBlue;
        end
        w_neg = w_diff[rhc_pkg::ChanW];
        w_abs = w_neg ? rhc_pkg::ChanW'(-w_diff) : w_diff[rhc_pkg::ChanW-1:0];

        // Saturation: (65536*delta + max) / (2*max).
        n_sat_ln.num = {w_delta, 16'd0} + rhc_pkg::NumW'(w_max);
        n_sat_ln.den = {w_max, 1'b0};
        n_sat_ln.rem = '0;
        n_sat_ln.quo = '0;

        // Hue offset: (7680*|n| + delta) / (2*delta).
        n_hue_ln.num = rhc_pkg::NumW'(rhc_pkg::NumW'(w_abs) * rhc_pkg::HueSixthX2)
                     + rhc_pkg::NumW'(w_delta);
        n_hue_ln.den = {w_delta, 1'b0};
        n_hue_ln.rem = '0;
        n_hue_ln.quo = '0;

        n_side.value = w_max;
        n_side.undef = (w_max == w_min);
        n_side.neg   = w_neg;
        n_side.base  = w_base;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r_sat_ln[0] <= n_sat_ln;
            r_hue_ln[0] <= n_hue_ln;
            r_side[0]   <= n_side;
        end
    end

    // Divider stages, four restoring steps per lane in each.
    for (genvar j = 1; j <= rhc_pkg::DivStages; j++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (w_adv[j+1]) begin
                r_sat_ln[j] <= rhc_pkg::div_step(r_sat_ln[j-1]);
                r_hue_ln[j] <= rhc_pkg::div_step(r_hue_ln[j-1]);
                r_side[j]   <= r_side[j-1];
            end
        end
    end

    // Output stage: apply the sign, wrap into one turn, and mask grey pixels.
    rhc_pkg::t_side           w_last;
    logic [rhc_pkg::HueW:0]   w_sum;
    logic [rhc_pkg::HueW:0]   w_mag;
    logic [rhc_pkg::HueW-1:0] n_hue;
    logic [rhc_pkg::SatW-1:0] n_sat;

    always_comb begin
        w_last = r_side[rhc_pkg::DivStages];
        w_mag  = (rhc_pkg::HueW+1)'(r_hue_ln[rhc_pkg::DivStages].quo[rhc_pkg::HueW-1:0]);
        if (w_last.neg) begin
            w_sum = {1'b0, w_last.base} - w_mag;
        end else begin
            w_sum = {1'b0, w_last.base} + w_mag;
        end
        if (w_sum[rhc_pkg::HueW]) begin
            w_sum = w_sum + rhc_pkg::HueFull;
        end
        n_hue = w_last.undef ? '0 : w_sum[rhc_pkg::HueW-1:0];
        n_sat = w_last.undef ? '0 : r_sat_ln[rhc_pkg::DivStages].quo[rhc_pkg::SatW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[OutSt]) begin
            r_hue   <= n_hue;
            r_sat   <= n_sat;
            r_value <= w_last.value;
            r_undef <= w_last.undef;
        end
    end

    assign o_valid         = r_vld[OutSt];
    assign o_hue           = r_hue;
    assign o_saturation    = r_sat;
    assign o_value         = r_value;
    assign o_hue_undefined = r_undef;

endmodule

`default_nettype wire
